>>> hw/rtl/gwm_pkg.sv
// ----------------------------------------------------------------------------
// gwm_pkg
// Shared constants and types for the glob wildcard matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gwm_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] ANY_CHAR  = 8'h3F;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_SUBJECT = 1'b1;

  // Signals handed from one position cell to the next one up.
  typedef struct packed {
    logic step;   // previous position consumed the character
    logic close;  // previous position is an active star
    logic seed;   // restart value carried over a leading star
  } gwm_link_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } gwm_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/gwm_cell.sv
// ----------------------------------------------------------------------------
// gwm_cell
// One pattern position: stored byte plus its bit of the position vector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gwm_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv_i,
  input  wire logic              pend_i,
  input  wire logic              wr_en_i,
  input  wire logic [7:0]        wr_char_i,
  input  wire logic [7:0]        sub_char_i,
  input  wire logic              used_i,
  input  wire logic              head_i,
  input  wire gwm_pkg::gwm_link_t lnk_i,
  output gwm_pkg::gwm_link_t     lnk_o,
  output logic                   closed_o
);

  logic [7:0] ch_r;
  logic       a_r;
  logic       a_nxt;
  logic       is_star;
  logic       star_act;
  logic       hit;
  logic       a_cur;
  logic       base;

  always_comb begin
    is_star  = (ch_r == gwm_pkg::STAR_CHAR);
    star_act = used_i & is_star;
    hit      = (ch_r == gwm_pkg::ANY_CHAR) | (ch_r == sub_char_i);
    a_cur    = pend_i ? (head_i | lnk_i.seed) : a_r;
    base     = (star_act & a_cur) | lnk_i.step;
    closed_o = base | lnk_i.close;
    a_nxt    = adv_i ? closed_o : a_r;
    lnk_o.step  = a_cur & used_i & ~is_star & hit;
    lnk_o.close = star_act & base;
    lnk_o.seed  = head_i & star_act;
  end

  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      ch_r <= wr_char_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= 1'b0;
    end else begin
      a_r <= a_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/gwm_skid.sv
// ----------------------------------------------------------------------------
// gwm_skid
// Two-entry result buffer: output register plus skid word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gwm_skid (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_i,
  input  wire gwm_pkg::gwm_res_t push_data_i,
  output logic                   full_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output gwm_pkg::gwm_res_t      out_data_o
);

  logic              out_valid_r, out_valid_nxt;
  logic              sk_valid_r, sk_valid_nxt;
  gwm_pkg::gwm_res_t out_r, out_nxt;
  gwm_pkg::gwm_res_t sk_r, sk_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    sk_valid_nxt  = sk_valid_r;
    out_nxt       = out_r;
    sk_nxt        = sk_r;
    if (!out_valid_r || out_ready_i) begin
      if (sk_valid_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = sk_r;
        sk_valid_nxt  = push_i;
        sk_nxt        = push_data_i;
      end else begin
        out_valid_nxt = push_i;
        out_nxt       = push_data_i;
      end
    end else if (push_i) begin
      sk_valid_nxt = 1'b1;
      sk_nxt       = push_data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sk_valid_r  <= sk_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    sk_r  <= sk_nxt;
  end

  assign full_o      = sk_valid_r;
  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_r;

endmodule

`default_nettype wire

>>> hw/rtl/glob_wildcard_matcher.sv
// ----------------------------------------------------------------------------
// glob_wildcard_matcher
// Glob matcher ('*' any run, '?' one byte) over a row of position cells.
// ----------------------------------------------------------------------------
// Takes one word per clock, pattern bytes and subject bytes alike. Each
// subject byte updates the whole position vector at once across the row of
// cells, so a new word can follow every cycle; the result of a final subject
// byte appears at the outputs in the cycle after it is taken when the
// output register is free. Results leave through a two-entry buffer, and
// input stalls while both entries are held, that is while a result waits in
// the skid word behind one the output has not yet handed off. Runs of stars
// are stored as a single star, which keeps the star closure to one cell step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module glob_wildcard_matcher (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_operation,
  input  wire logic [7:0] in_character,
  input  wire logic       in_final_char,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_matched,
  output logic            out_pattern_overflow
);

  localparam int MAX = gwm_pkg::MAX_PATTERN;
  localparam int LW  = gwm_pkg::LEN_W;

  logic [LW-1:0] slen_r, slen_nxt;
  logic [LW-1:0] olen_r, olen_nxt;
  logic          ovf_r, ovf_nxt;
  logic          complete_r, complete_nxt;
  logic          last_star_r, last_star_nxt;
  logic          pend_r, pend_nxt;

  logic          acc;
  logic          load_acc;
  logic          sub_acc;
  logic          restart;
  logic [LW-1:0] slen_eff;
  logic [LW-1:0] olen_eff;
  logic          last_star_eff;
  logic          in_star;
  logic          room;
  logic          store;
  logic          full;

  logic [MAX-1:0]     wr_en;
  logic [MAX-1:0]     used;
  logic [MAX:0]       closed_v;
  gwm_pkg::gwm_link_t lnk [MAX+1];
  gwm_pkg::gwm_res_t  res;
  gwm_pkg::gwm_res_t  out_data;

  assign in_ready = ~full;
  assign acc      = in_valid & in_ready;
  assign load_acc = acc & (in_operation == gwm_pkg::OP_LOAD);
  assign sub_acc  = acc & (in_operation == gwm_pkg::OP_SUBJECT);

  always_comb begin
    restart       = complete_r;
    slen_eff      = restart ? '0 : slen_r;
    olen_eff      = restart ? '0 : olen_r;
    last_star_eff = restart ? 1'b0 : last_star_r;
    in_star       = (in_character == gwm_pkg::STAR_CHAR);
    room          = (olen_eff < LW'(MAX));
    store         = room & ~(in_star & last_star_eff);

    slen_nxt      = slen_r;
    olen_nxt      = olen_r;
    ovf_nxt       = ovf_r;
    complete_nxt  = complete_r;
    last_star_nxt = last_star_r;
    pend_nxt      = pend_r;

    if (load_acc) begin
      complete_nxt  = in_final_char;
      pend_nxt      = 1'b1;
      ovf_nxt       = (restart ? 1'b0 : ovf_r) | ~room;
      olen_nxt      = room ? (olen_eff + LW'(1)) : olen_eff;
      slen_nxt      = store ? (slen_eff + LW'(1)) : slen_eff;
      last_star_nxt = store ? in_star : last_star_eff;
    end else if (sub_acc) begin
      pend_nxt = in_final_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slen_r      <= '0;
      olen_r      <= '0;
      ovf_r       <= 1'b0;
      complete_r  <= 1'b0;
      last_star_r <= 1'b0;
      pend_r      <= 1'b1;
    end else begin
      slen_r      <= slen_nxt;
      olen_r      <= olen_nxt;
      ovf_r       <= ovf_nxt;
      complete_r  <= complete_nxt;
      last_star_r <= last_star_nxt;
      pend_r      <= pend_nxt;
    end
  end

  assign lnk[0] = '0;

  for (genvar i = 0; i < MAX; i++) begin : g_cell
    assign wr_en[i] = load_acc & store & (slen_eff == LW'(i));
    assign used[i]  = (LW'(i) < slen_r);

    gwm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv_i      (sub_acc),
      .pend_i     (pend_r),
      .wr_en_i    (wr_en[i]),
      .wr_char_i  (in_character),
      .sub_char_i (in_character),
      .used_i     (used[i]),
      .head_i     (i == 0),
      .lnk_i      (lnk[i]),
      .lnk_o      (lnk[i+1]),
      .closed_o   (closed_v[i])
    );
  end

  assign closed_v[MAX] = lnk[MAX].step | lnk[MAX].close;

  assign res.matched  = closed_v[slen_r];
  assign res.overflow = ovf_r;

  gwm_skid u_skid (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (sub_acc & in_final_char),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  assign out_matched          = out_data.matched;
  assign out_pattern_overflow = out_data.overflow;

  a_len_order: assert property (@(posedge clk) disable iff (!rst_n)
    (slen_r <= olen_r) && (olen_r <= LW'(MAX)))
    else $error("stored length exceeds loaded length");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (olen_r == LW'(MAX)))
    else $error("overflow set with room left");

  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    (sub_acc && in_final_char) |=> out_valid)
    else $error("final subject byte gave no result");

  a_load_restart: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> pend_r)
    else $error("pattern load did not restart positions");

endmodule

`default_nettype wire
